@@ sv/ctu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code-page / UTF-8 transcoder package
// Shared types, constants and helper functions for the transcoder core.
// ----------------------------------------------------------------------------
package ctu_pkg;

  // Reverse table geometry
  localparam int unsigned REV_DEPTH = 512;
  localparam int unsigned REV_AW    = $clog2(REV_DEPTH);
  localparam int unsigned REV_CW    = REV_AW + 1;

  // Command queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] REPL_BYTE = 8'h3F;

  typedef enum logic [2:0] {
    FN_LOAD   = 3'd0,
    FN_APPEND = 3'd1,
    FN_ENCODE = 3'd2,
    FN_DECODE = 3'd3,
    FN_RECODE = 3'd4,
    FN_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Work handed from front to back
  typedef enum logic [2:0] {
    CMD_DIRECT,
    CMD_ERR,
    CMD_ENC,
    CMD_LOOK,
    CMD_APPEND,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  byte_value;
    logic [15:0] code_point;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_e        op;
    logic [15:0] code;
    logic [7:0]  byt;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PROBE,
    BK_CMP,
    BK_EMIT
  } back_state_e;

  // Trailing byte count of a UTF-8 lead byte
  function automatic logic [2:0] trail_of(input logic [7:0] b);
    logic [2:0] t;
    if (b < 8'hC0)      t = 3'd0;
    else if (b < 8'hE0) t = 3'd1;
    else if (b < 8'hF0) t = 3'd2;
    else if (b < 8'hF8) t = 3'd3;
    else if (b < 8'hFC) t = 3'd4;
    else                t = 3'd5;
    return t;
  endfunction

  // Offset removed from a finished sequence
  function automatic logic [31:0] seq_offset(input logic [2:0] len);
    logic [31:0] o;
    case (len)
      3'd1:    o = 32'h0000_3080;
      3'd2:    o = 32'h000E_2080;
      3'd3:    o = 32'h03C8_2080;
      3'd4:    o = 32'hFA08_2080;
      3'd5:    o = 32'h8208_2080;
      default: o = 32'h0;
    endcase
    return o;
  endfunction

endpackage

@@ sv/ctu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts transactions, owns the forward table and the UTF-8 decode state,
// and turns each transaction into a command for the back end.
// ----------------------------------------------------------------------------
module ctu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ctu_pkg::in_item_t in_item_i,
  output logic              cmd_valid_o,
  output ctu_pkg::cmd_t     cmd_o,
  input  logic              cmd_full_i
);
  import ctu_pkg::*;

  front_state_e state_q, state_d;
  cmd_t         cmd_q, cmd_d;
  logic         enc_q;
  logic [2:0]   pend_q, pend_d;
  logic [2:0]   len_q, len_d;
  logic [31:0]  acc_q, acc_d;

  logic [15:0]  fwd_mem [256];
  logic [255:0] fwd_vld_q;
  logic [15:0]  rd_code_q;
  logic         rd_vld_q;
  logic [15:0]  fwd_code;

  logic         accept;
  logic         ascii;
  logic         done;
  logic [2:0]   pt_n, len_n;
  logic [31:0]  acc_n, dec_val;
  logic         has_cmd;
  logic [7:0]   b;

  assign b          = in_item_i.byte_value;
  assign accept     = in_valid_i && (state_q == FR_IDLE);
  assign in_stall_o = (state_q != FR_IDLE);
  assign cmd_valid_o = (state_q == FR_PUSH);
  assign cmd_o      = cmd_q;
  assign fwd_code   = rd_vld_q ? rd_code_q : 16'h0;

  // UTF-8 sequence assembly
  always_comb begin
    ascii = (pend_q == 3'd0) && !b[7];
    if (pend_q == 3'd0) begin
      len_n = trail_of(b);
      pt_n  = len_n;
      acc_n = {24'h0, b};
    end else begin
      len_n = len_q;
      pt_n  = pend_q - 3'd1;
      acc_n = {acc_q[25:0], 6'h0} + {24'h0, b};
    end
    done    = !ascii && (pt_n == 3'd0);
    dec_val = acc_n - seq_offset(len_n);
  end

  // Command built at accept or after the forward read
  always_comb begin
    cmd_d   = cmd_q;
    has_cmd = 1'b0;
    if (state_q == FR_READ) begin
      if (enc_q) begin
        cmd_d = '{op: CMD_ENC, code: fwd_code, byt: 8'h0};
      end else if (fwd_code == 16'h0) begin
        cmd_d = '{op: CMD_DIRECT, code: 16'h0, byt: REPL_BYTE};
      end else begin
        cmd_d = '{op: CMD_LOOK, code: fwd_code, byt: 8'h0};
      end
    end else if (accept) begin
      case (in_item_i.func)
        FN_APPEND: begin
          cmd_d   = '{op: CMD_APPEND, code: in_item_i.code_point, byt: b};
          has_cmd = 1'b1;
        end
        FN_CLEAR: begin
          cmd_d   = '{op: CMD_CLEAR, code: 16'h0, byt: 8'h0};
          has_cmd = 1'b1;
        end
        FN_DECODE: begin
          if (ascii) begin
            cmd_d   = '{op: CMD_DIRECT, code: 16'h0, byt: b};
            has_cmd = 1'b1;
          end else if (done) begin
            has_cmd = 1'b1;
            if (dec_val[31:16] != 16'h0) begin
              cmd_d = '{op: CMD_ERR, code: 16'h0, byt: 8'h0};
            end else begin
              cmd_d = '{op: CMD_LOOK, code: dec_val[15:0], byt: 8'h0};
            end
          end
        end
        default: has_cmd = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (accept) begin
          if (in_item_i.func == FN_ENCODE || in_item_i.func == FN_RECODE) begin
            state_d = FR_READ;
          end else if (has_cmd) begin
            state_d = FR_PUSH;
          end
        end
      end
      FR_READ: state_d = FR_PUSH;
      FR_PUSH: if (!cmd_full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  // Pending decode state
  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    acc_d  = acc_q;
    if (accept) begin
      if (in_item_i.func == FN_DECODE && !ascii) begin
        if (done) begin
          pend_d = 3'd0;
          len_d  = 3'd0;
          acc_d  = 32'h0;
        end else begin
          pend_d = pt_n;
          len_d  = len_n;
          acc_d  = acc_n;
        end
      end
      if (in_item_i.end_of_text) begin
        pend_d = 3'd0;
        len_d  = 3'd0;
        acc_d  = 32'h0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FR_IDLE;
      pend_q    <= 3'd0;
      len_q     <= 3'd0;
      acc_q     <= 32'h0;
      fwd_vld_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      if (accept && in_item_i.func == FN_LOAD) fwd_vld_q[b] <= 1'b1;
    end
  end

  // Forward table and payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (accept) begin
      enc_q     <= (in_item_i.func == FN_ENCODE);
      rd_code_q <= fwd_mem[b];
      rd_vld_q  <= fwd_vld_q[b];
      if (in_item_i.func == FN_LOAD) fwd_mem[b] <= in_item_i.code_point;
    end
  end

endmodule

@@ sv/ctu_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ctu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ctu_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ctu_pkg::cmd_t cmd_o
);
  import ctu_pkg::*;

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slots[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + {{Q_AW{1'b0}}, do_push} - {{Q_AW{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots[wr_ptr_q] <= cmd_i;
  end

endmodule

@@ sv/ctu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder back end
// Owns the reverse table, runs the binary search and emits result bytes
// through a registered output stage.
// ----------------------------------------------------------------------------
module ctu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  ctu_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ctu_pkg::out_item_t out_item_o
);
  import ctu_pkg::*;

  back_state_e       state_q, state_d;
  logic [REV_CW-1:0] count_q;
  logic [REV_CW-1:0] lo_q, hi_q;
  logic [REV_AW-1:0] mid_q;
  logic [15:0]       key_q;
  logic [23:0]       rd_q;
  logic [2:0][7:0]   buf_q;
  logic [1:0]        n_q, idx_q;
  logic [1:0]        st_q;
  out_item_t         out_q;
  logic              out_valid_q;

  logic [23:0]       rev_mem [REV_DEPTH];

  logic              can_emit;
  logic              emit_last;
  logic [REV_CW-1:0] mid_w, lo_up, hi_dn;
  logic [15:0]       code_m;
  logic [7:0]        byte_m;
  logic              hit, go_up, miss;
  logic [2:0][7:0]   enc_b;
  logic [1:0]        enc_n;
  logic              room;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign emit_last   = (idx_q == n_q);
  assign room        = (count_q < REV_CW'(REV_DEPTH));

  // Search datapath; entry 0 always holds code 0 / byte 0
  assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);
  assign code_m = (mid_q == '0) ? 16'h0 : rd_q[23:8];
  assign byte_m = (mid_q == '0) ? 8'h0 : rd_q[7:0];
  assign lo_up  = {1'b0, mid_q} + REV_CW'(1);
  assign hi_dn  = {1'b0, mid_q} - REV_CW'(1);
  assign hit    = (key_q == code_m);
  assign go_up  = (key_q > code_m);
  always_comb begin
    if (hit)        miss = 1'b0;
    else if (go_up) miss = (lo_up > hi_q);
    else            miss = (mid_q == '0) || (lo_q > hi_dn);
  end

  // UTF-8 encoder
  always_comb begin
    enc_b = '0;
    enc_n = 2'd0;
    if (cmd_i.code == 16'h0) begin
      enc_b[0] = REPL_BYTE;
    end else if (cmd_i.code < 16'h0080) begin
      enc_b[0] = cmd_i.code[7:0];
    end else if (cmd_i.code < 16'h0800) begin
      enc_b[0] = {3'b110, cmd_i.code[10:6]};
      enc_b[1] = {2'b10, cmd_i.code[5:0]};
      enc_n    = 2'd1;
    end else begin
      enc_b[0] = {4'b1110, cmd_i.code[15:12]};
      enc_b[1] = {2'b10, cmd_i.code[11:6]};
      enc_b[2] = {2'b10, cmd_i.code[5:0]};
      enc_n    = 2'd2;
    end
  end

  // Control outputs
  always_comb begin
    pop_o = (state_q == BK_IDLE) && !empty_i;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          case (cmd_i.op)
            CMD_LOOK:   state_d = BK_PROBE;
            CMD_CLEAR:  state_d = BK_IDLE;
            CMD_APPEND: state_d = room ? BK_IDLE : BK_EMIT;
            default:    state_d = BK_EMIT;
          endcase
        end
      end
      BK_PROBE: state_d = BK_CMP;
      BK_CMP:   state_d = (hit || miss) ? BK_EMIT : BK_PROBE;
      BK_EMIT:  if (can_emit && emit_last) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= REV_CW'(1);
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_IDLE && !empty_i) begin
        if (cmd_i.op == CMD_CLEAR) count_q <= REV_CW'(1);
        if (cmd_i.op == CMD_APPEND && room) count_q <= count_q + REV_CW'(1);
      end
      if (state_q == BK_EMIT && can_emit) begin
        out_valid_q <= 1'b1;
        idx_q       <= emit_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and reverse table
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE && !empty_i) begin
      buf_q <= '0;
      n_q   <= 2'd0;
      st_q  <= ST_OK;
      case (cmd_i.op)
        CMD_DIRECT: buf_q[0] <= cmd_i.byt;
        CMD_ERR:    st_q <= ST_RANGE;
        CMD_ENC: begin
          buf_q <= enc_b;
          n_q   <= enc_n;
        end
        CMD_LOOK: begin
          key_q <= cmd_i.code;
          lo_q  <= '0;
          hi_q  <= count_q - REV_CW'(1);
        end
        CMD_APPEND: begin
          if (room) rev_mem[count_q[REV_AW-1:0]] <= {cmd_i.code, cmd_i.byt};
          else      st_q <= ST_FULL;
        end
        default: st_q <= ST_OK;
      endcase
    end
    if (state_q == BK_PROBE) begin
      mid_q <= mid_w[REV_AW-1:0];
      rd_q  <= rev_mem[mid_w[REV_AW-1:0]];
    end
    if (state_q == BK_CMP) begin
      if (hit)        buf_q[0] <= byte_m;
      else if (miss)  buf_q[0] <= REPL_BYTE;
      else if (go_up) lo_q <= lo_up;
      else            hi_q <= hi_dn;
    end
    if (state_q == BK_EMIT && can_emit) begin
      out_q.out_byte <= buf_q[idx_q];
      out_q.status   <= st_q;
      out_q.last     <= emit_last;
    end
  end

  // Checks
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0) else $error("reverse count dropped to zero");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= REV_CW'(REV_DEPTH)) else $error("reverse count beyond depth");
  a_probe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_CMP |-> $past(state_q) == BK_PROBE)
    else $error("compare without a probe");
  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PROBE |-> lo_q <= hi_q) else $error("probe on empty window");

endmodule

@@ sv/codepage_utf8_transcoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code-page / UTF-8 transcoder core
// Encodes, decodes and recodes single-byte code-page text through a forward
// byte table and a sorted reverse table searched by binary search.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | in_item_i
//  out     | output    | out_valid_o / out_stall_i   | out_item_o
//
//  The front end takes a new transaction only when idle; a forward table read
//  and a queue push each delay the next. A lookup runs up to log2(512)+1 search
//  probes, each a probe state then a compare state (set by the reverse table
//  memory port), then emits its result bytes. Reset empties the queue, clears
//  the forward table and leaves one reverse entry; no clearing pass is needed.
//  A full command queue stalls the input; a stalled output holds the back end.
// ----------------------------------------------------------------------------
module codepage_utf8_transcoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ctu_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ctu_pkg::out_item_t out_item_o
);
  import ctu_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic front_valid, queue_full, queue_empty, queue_pop;

  ctu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_full_i  (queue_full)
  );

  ctu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .cmd_o   (queue_cmd)
  );

  ctu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (queue_empty),
    .cmd_i       (queue_cmd),
    .pop_o       (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ test/codepage_utf8_transcoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transcoder core testbench
// Drives table loads, encode, UTF-8 decode and recode transactions with random
// idle bursts on both sides, predicts every output byte from a local copy of
// the tables and checks each result in order.
// ----------------------------------------------------------------------------
module codepage_utf8_transcoder_core_tb;
  import ctu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  codepage_utf8_transcoder_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [15:0] fwd_map [256];
  logic [15:0] rev_code [REV_DEPTH];
  logic [7:0]  rev_byte [REV_DEPTH];
  int unsigned rev_count;
  int unsigned seq_left, seq_len;
  logic [31:0] seq_acc;

  out_item_t   pending_bytes[$];
  int unsigned err_count = 0;
  int unsigned result_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit          rx_quiet = 1'b0;     // no output stalls in the last part
  bit          hold_req = 1'b0;     // long receiver hold-off request

  task automatic report(input string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  function automatic logic [7:0] rev_search(input logic [15:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = int'(rev_count) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (key > rev_code[mid]) lo = mid + 1;
      else if (key < rev_code[mid]) begin
        if (mid == 0) break;
        hi = mid - 1;
      end else return rev_byte[mid];
    end
    return REPL_BYTE;
  endfunction

  function automatic out_item_t mk(input logic [7:0] b, input status_e st, input bit l);
    out_item_t r;
    r.out_byte = b;
    r.status = st;
    r.last = l;
    return r;
  endfunction

  // Advance the predictor by one transaction and queue its results
  task automatic predict_transcode(input in_item_t it);
    logic [15:0] c;
    logic [31:0] v, off;
    logic [7:0]  b;
    b = it.byte_value;
    case (it.func)
      FN_LOAD: fwd_map[b] = it.code_point;
      FN_APPEND: begin
        if (rev_count < REV_DEPTH) begin
          rev_code[rev_count] = it.code_point;
          rev_byte[rev_count] = b;
          rev_count++;
        end else pending_bytes.push_back(mk(8'h00, ST_FULL, 1'b1));
      end
      FN_ENCODE: begin
        c = fwd_map[b];
        if (c == 0) pending_bytes.push_back(mk(REPL_BYTE, ST_OK, 1'b1));
        else if (c < 16'h80) pending_bytes.push_back(mk(c[7:0], ST_OK, 1'b1));
        else if (c < 16'h800) begin
          pending_bytes.push_back(mk(8'hC0 | 8'(c >> 6), ST_OK, 1'b0));
          pending_bytes.push_back(mk(8'h80 | 8'(c & 16'h3F), ST_OK, 1'b1));
        end else begin
          pending_bytes.push_back(mk(8'hE0 | 8'(c >> 12), ST_OK, 1'b0));
          pending_bytes.push_back(mk(8'h80 | 8'((c >> 6) & 16'h3F), ST_OK, 1'b0));
          pending_bytes.push_back(mk(8'h80 | 8'(c & 16'h3F), ST_OK, 1'b1));
        end
      end
      FN_DECODE: begin
        if (seq_left == 0 && b <= 8'h7F) begin
          pending_bytes.push_back(mk(b, ST_OK, 1'b1));
        end else begin
          if (seq_left == 0) begin
            seq_len = b < 8'hC0 ? 0 : b < 8'hE0 ? 1 : b < 8'hF0 ? 2 :
                      b < 8'hF8 ? 3 : b < 8'hFC ? 4 : 5;
            seq_left = seq_len;
            seq_acc = {24'h0, b};
          end else begin
            seq_acc = (seq_acc << 6) + {24'h0, b};
            seq_left--;
          end
          if (seq_left == 0) begin
            case (seq_len)
              1: off = 32'h0000_3080;
              2: off = 32'h000E_2080;
              3: off = 32'h03C8_2080;
              4: off = 32'hFA08_2080;
              5: off = 32'h8208_2080;
              default: off = 32'h0;
            endcase
            v = seq_acc - off;
            if (v[31:16] != 0) pending_bytes.push_back(mk(8'h00, ST_RANGE, 1'b1));
            else pending_bytes.push_back(mk(rev_search(v[15:0]), ST_OK, 1'b1));
            seq_left = 0; seq_len = 0; seq_acc = 0;
          end
        end
      end
      FN_RECODE: begin
        c = fwd_map[b];
        pending_bytes.push_back(mk(c != 0 ? rev_search(c) : REPL_BYTE, ST_OK, 1'b1));
      end
      FN_CLEAR: begin
        rev_code[0] = 0; rev_byte[0] = 0; rev_count = 1;
      end
      default: ;
    endcase
    if (it.end_of_text) begin
      seq_left = 0; seq_len = 0; seq_acc = 0;
    end
  endtask

  // Send one transaction, with an optional random idle burst first
  task automatic send_item(input in_item_t it, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_transcode(it);
    sent_count++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic in_item_t item(input func_e f, input logic [7:0] b,
                                    input logic [15:0] cp, input bit eot);
    in_item_t it;
    it.func = f; it.byte_value = b; it.code_point = cp; it.end_of_text = eot;
    return it;
  endfunction

  // Random text transaction; mostly well-formed UTF-8 sequences when decoding
  task automatic send_random_text(input bit may_idle);
    int unsigned k, n;
    in_item_t it;
    k = $urandom_range(0, 9);
    if (k < 3) begin
      n = $urandom_range(1, 2);
      send_item(item(FN_DECODE, n == 1 ? 8'(8'hC0 | $urandom_range(0, 31))
                                         : 8'(8'hE0 | $urandom_range(0, 15)),
                     16'h0, 1'b0), may_idle);
      for (int i = 0; i < int'(n); i++)
        send_item(item(FN_DECODE, 8'(8'h80 | $urandom_range(0, 63)), 16'h0,
                       $urandom_range(0, 15) == 0), may_idle);
    end else begin
      it = in_item_t'($urandom);
      if (k < 5) it.func = FN_ENCODE;
      else if (k < 7) it.func = FN_RECODE;
      else if (k < 8) it.func = FN_DECODE;
      it.end_of_text = ($urandom_range(0, 7) == 0);
      if (it.func == FN_APPEND || it.func == FN_CLEAR || it.func == FN_LOAD)
        it.func = FN_DECODE;
      send_item(it, may_idle);
    end
  endtask

  // Output side: random stall bursts, long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        n = 300;
        while (n != 0) begin
          @(posedge clk_i);
          n--;
        end
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (pending_bytes.size() == 0) report("result with nothing expected");
      else begin
        want = pending_bytes.pop_front();
        if (out_item_o.out_byte !== want.out_byte)
          report($sformatf("out_byte %h want %h", out_item_o.out_byte, want.out_byte));
        if (out_item_o.status !== want.status)
          report($sformatf("status %0d want %0d", out_item_o.status, want.status));
        if (out_item_o.last !== want.last)
          report($sformatf("last %0b want %0b", out_item_o.last, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    in_item_t    it;
    bit          check;
    logic [7:0]  b0;
    status_e     st0;
  } row_t;

  row_t        rows[$];
  out_item_t   got_first;
  int unsigned held;

  initial begin
    fwd_map = '{default: 16'h0};
    rev_code = '{default: 16'h0};
    rev_byte = '{default: 8'h0};
    rev_count = 1; seq_left = 0; seq_len = 0; seq_acc = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed expectation where obvious, predictor otherwise
    rows.push_back('{item(FN_ENCODE, 8'h00, 16'h0, 1'b0), 1, REPL_BYTE, ST_OK});
    rows.push_back('{item(FN_RECODE, 8'hFF, 16'h0, 1'b0), 1, REPL_BYTE, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'h7F, 16'h0, 1'b0), 1, 8'h7F, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'h00, 16'h0, 1'b0), 1, 8'h00, ST_OK});
    rows.push_back('{item(FN_LOAD, 8'h41, 16'h0041, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_LOAD, 8'hFF, 16'hFFFF, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_LOAD, 8'hC4, 16'h0410, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_LOAD, 8'h80, 16'h07FF, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_APPEND, 8'h41, 16'h0041, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_APPEND, 8'hC4, 16'h0410, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_APPEND, 8'hFF, 16'hFFFF, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_ENCODE, 8'h41, 16'h0, 1'b0), 1, 8'h41, ST_OK});
    rows.push_back('{item(FN_ENCODE, 8'hFF, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_ENCODE, 8'h80, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_RECODE, 8'hFF, 16'h0, 1'b0), 1, 8'hFF, ST_OK});
    rows.push_back('{item(FN_RECODE, 8'h80, 16'h0, 1'b0), 1, REPL_BYTE, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'hD0, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'h90, 16'h0, 1'b0), 1, 8'hC4, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'hFC, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'hBF, 16'h0, 1'b1), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'hF0, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    for (int i = 0; i < 3; i++)
      rows.push_back('{item(FN_DECODE, 8'hBF, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(FN_DECODE, 8'h80, 16'h0, 1'b0), 0, 8'h0, ST_OK});
    rows.push_back('{item(func_e'(3'd6), 8'h55, 16'hAAAA, 1'b1), 0, 8'h0, ST_OK});
    rows.push_back('{item(func_e'(3'd7), 8'hAA, 16'h5555, 1'b0), 0, 8'h0, ST_OK});
    foreach (rows[i]) begin
      send_item(rows[i].it, 1'b1);
      if (rows[i].check) begin
        got_first = pending_bytes[$];
        if (got_first.out_byte !== rows[i].b0 || got_first.status !== rows[i].st0)
          report($sformatf("directed row %0d prediction disagrees", i));
      end
    end
    // Out-of-range four-byte sequence: status 2 expected
    send_item(item(FN_DECODE, 8'hF4, 16'h0, 1'b0), 1'b1);
    send_item(item(FN_DECODE, 8'h90, 16'h0, 1'b0), 1'b1);
    send_item(item(FN_DECODE, 8'h80, 16'h0, 1'b0), 1'b1);
    send_item(item(FN_DECODE, 8'h80, 16'h0, 1'b0), 1'b1);
    if (pending_bytes.size() == 0 || pending_bytes[$].status !== ST_RANGE)
      report("range error not predicted");
    go_idle();

    // Small sorted reverse table, then search its top entry
    send_item(item(FN_CLEAR, 8'h00, 16'h0, 1'b0), 1'b1);
    for (int i = 1; i < 12; i++)
      send_item(item(FN_APPEND, 8'(i), 16'(i * 100), 1'b0), 1'b0);
    send_item(item(FN_LOAD, 8'h01, 16'(11 * 100), 1'b0), 1'b0);
    send_item(item(FN_RECODE, 8'h01, 16'h0, 1'b0), 1'b1);
    if (pending_bytes.size() == 0 || pending_bytes[$].out_byte !== 8'd11)
      report("top entry not predicted");
    go_idle();

    // Long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    for (int i = 0; i < 15; i++) send_random_text(1'b0);
    go_idle();

    // Random part, small reverse table that can be hit by decode too
    send_item(item(FN_CLEAR, 8'h00, 16'h0, 1'b0), 1'b1);
    for (int i = 1; i < 16; i++)
      send_item(item(FN_APPEND, 8'($urandom), 16'(i * 50 + $urandom_range(0, 49)), 1'b0),
                1'b1);
    for (int i = 0; i < 28; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(item(FN_LOAD, 8'($urandom), 16'($urandom), 1'b0), 1'b1);
      send_random_text(1'b1);
    end
    go_idle();
    rx_quiet = 1'b1;
    for (int i = 0; i < 8; i++) send_random_text(1'b0);
    in_valid_i <= 1'b0;

    // Drain
    held = 0;
    while (pending_bytes.size() != 0 && held < 20000) begin
      @(posedge clk_i);
      held++;
    end
    repeat (60) @(posedge clk_i);
    $display("covered %0d transactions, %0d results: loads, appends, encode,",
             sent_count, result_count);
    $display("UTF-8 decode incl. cut-off and out-of-range sequences, recode");
    if (err_count == 0 && pending_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d errors, %0d results missing", err_count, pending_bytes.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ctu_pkg.sv
sv/ctu_front.sv
sv/ctu_fifo.sv
sv/ctu_back.sv
sv/codepage_utf8_transcoder_core.sv
test/codepage_utf8_transcoder_core_tb.sv
